FILE: design/ipv6tp_pkg.sv
// shared types and constants for the ipv6 text address parser
package ipv6tp_pkg;

  localparam int NUM_GROUPS = 8;
  localparam int GROUP_W    = 16;
  localparam int GIDX_W     = 3;
  localparam int GCNT_W     = 4;
  localparam int HALF_W     = 64;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_COLON    = 8'h3a;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_RBRACKET = 8'h5d;
  localparam logic [7:0] CH_SLASH    = 8'h2f;
  localparam logic [7:0] CH_DIG0     = 8'h30;
  localparam logic [7:0] CH_DIG9     = 8'h39;
  localparam logic [7:0] CH_LOW_A    = 8'h61;
  localparam logic [7:0] CH_LOW_F    = 8'h66;
  localparam logic [7:0] CH_UP_A     = 8'h41;
  localparam logic [7:0] CH_UP_F     = 8'h46;

  localparam logic [1:0] STOP_NUL     = 2'd0;
  localparam logic [1:0] STOP_BRACKET = 2'd1;
  localparam logic [1:0] STOP_SLASH   = 2'd2;
  localparam logic [1:0] STOP_ERROR   = 2'd3;

  typedef logic [NUM_GROUPS-1:0][GROUP_W-1:0] group_vec_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
  } emit_t;

  typedef struct packed {
    logic              good;
    logic              gap_seen;
    logic [GCNT_W-1:0] count;
    logic [GIDX_W-1:0] gap_pos;
  } expand_ctl_t;

endpackage

FILE: design/ipv6_text_address_parser.sv
// top level: input register, parse and expansion, result register
// Takes one character of an IPv6 address text per word and returns one word with the 128-bit
// address when the text ends (NUL, ']' or '/') or an error is found. Each character is
// registered on entry and then handled by a single pass of parse logic and the zero-run
// expansion mux, whose result lands in the output register; a new character is taken every
// cycle while the output register is empty or its result is being taken, and while the
// output register holds a result that is not taken, the input register holds its character
// and input stalls.
// After a result that did not end on NUL, characters up to and including the next NUL are
// consumed without a result.
module ipv6_text_address_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] addr_high,
  output logic [63:0] addr_low,
  output logic        ok,
  output logic [1:0]  stop_kind
);

  logic       ch_valid;
  logic [7:0] ch_q;
  logic       advance;
  logic       fire;

  ipv6tp_pkg::emit_t       emit;
  ipv6tp_pkg::expand_ctl_t ctl;
  ipv6tp_pkg::group_vec_t  store_view;
  logic [63:0]             exp_high;
  logic [63:0]             exp_low;

  assign advance  = !out_valid || out_ready;
  assign fire     = ch_valid && advance;
  assign in_ready = !ch_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_valid <= 1'b0;
    end else if (in_ready) begin
      ch_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ch_q <= ch;
    end
  end

  ipv6tp_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .ch         (ch_q),
    .emit       (emit),
    .ctl        (ctl),
    .store_view (store_view)
  );

  ipv6tp_expand u_expand (
    .ctl        (ctl),
    .store_view (store_view),
    .addr_high  (exp_high),
    .addr_low   (exp_low)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit.valid) begin
      addr_high <= exp_high;
      addr_low  <= exp_low;
      ok        <= ctl.good;
      stop_kind <= emit.kind;
    end
  end

endmodule

FILE: design/ipv6tp_scan.sv
// per-character parse state, group store and end-of-parse decision
module ipv6tp_scan (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic [7:0]             ch,
  output ipv6tp_pkg::emit_t       emit,
  output ipv6tp_pkg::expand_ctl_t ctl,
  output ipv6tp_pkg::group_vec_t  store_view
);

  logic [ipv6tp_pkg::GROUP_W-1:0] group_acc, group_acc_next;
  logic [ipv6tp_pkg::GCNT_W-1:0]  group_cnt, group_cnt_next;
  logic [ipv6tp_pkg::GIDX_W-1:0]  gap_pos, gap_pos_next;
  logic gap_seen, gap_seen_next;
  logic after_colon, after_colon_next;
  logic at_first_char, at_first_char_next;
  logic skipping, skipping_next;
  ipv6tp_pkg::group_vec_t group_store;

  logic                           wr_en;
  logic [ipv6tp_pkg::GIDX_W-1:0]  wr_idx;
  logic                           is_hex;
  logic [3:0]                     hex_val;
  logic                           is_term;

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (ch >= ipv6tp_pkg::CH_DIG0 && ch <= ipv6tp_pkg::CH_DIG9) begin
      hex_val = 4'(ch - ipv6tp_pkg::CH_DIG0);
    end else if (ch >= ipv6tp_pkg::CH_LOW_A && ch <= ipv6tp_pkg::CH_LOW_F) begin
      hex_val = 4'(ch - ipv6tp_pkg::CH_LOW_A + 8'd10);
    end else if (ch >= ipv6tp_pkg::CH_UP_A && ch <= ipv6tp_pkg::CH_UP_F) begin
      hex_val = 4'(ch - ipv6tp_pkg::CH_UP_A + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign is_term = (ch == ipv6tp_pkg::CH_NUL) || (ch == ipv6tp_pkg::CH_RBRACKET) ||
                   (ch == ipv6tp_pkg::CH_SLASH);
  assign wr_idx  = group_cnt[ipv6tp_pkg::GIDX_W-1:0];

  always_comb begin
    group_acc_next     = group_acc;
    group_cnt_next     = group_cnt;
    gap_pos_next       = gap_pos;
    gap_seen_next      = gap_seen;
    after_colon_next   = after_colon;
    at_first_char_next = at_first_char;
    skipping_next      = skipping;
    wr_en              = 1'b0;
    emit.valid         = 1'b0;
    emit.kind          = ipv6tp_pkg::STOP_ERROR;
    ctl.good           = 1'b0;

    if (skipping) begin
      if (ch == ipv6tp_pkg::CH_NUL) begin
        skipping_next = 1'b0;
      end
    end else begin
      at_first_char_next = 1'b0;
      if (at_first_char && ch == ipv6tp_pkg::CH_LBRACKET) begin
        // leading bracket skipped
      end else if (after_colon && ch == ipv6tp_pkg::CH_COLON) begin
        after_colon_next = 1'b0;
        if (!gap_seen) begin
          gap_seen_next = 1'b1;
          gap_pos_next  = group_cnt[ipv6tp_pkg::GIDX_W-1:0];
        end
      end else begin
        after_colon_next = 1'b0;
        if (ch == ipv6tp_pkg::CH_COLON || is_term) begin
          wr_en          = 1'b1;
          group_cnt_next = group_cnt + 1'b1;
          group_acc_next = '0;
          if (ch == ipv6tp_pkg::CH_COLON) begin
            if (group_cnt_next == ipv6tp_pkg::GCNT_W'(ipv6tp_pkg::NUM_GROUPS)) begin
              emit.valid = 1'b1;
              emit.kind  = ipv6tp_pkg::STOP_ERROR;
            end else begin
              after_colon_next = 1'b1;
            end
          end else begin
            emit.valid = 1'b1;
            ctl.good   = gap_seen ||
                         (group_cnt_next == ipv6tp_pkg::GCNT_W'(ipv6tp_pkg::NUM_GROUPS));
            if (ch == ipv6tp_pkg::CH_NUL) begin
              emit.kind = ipv6tp_pkg::STOP_NUL;
            end else if (ch == ipv6tp_pkg::CH_RBRACKET) begin
              emit.kind = ipv6tp_pkg::STOP_BRACKET;
            end else begin
              emit.kind = ipv6tp_pkg::STOP_SLASH;
            end
          end
        end else if (is_hex) begin
          group_acc_next = {group_acc[ipv6tp_pkg::GROUP_W-5:0], hex_val};
        end else begin
          emit.valid = 1'b1;
          emit.kind  = ipv6tp_pkg::STOP_ERROR;
        end
      end
    end

    ctl.gap_seen = gap_seen;
    ctl.count    = group_cnt_next;
    ctl.gap_pos  = gap_pos;

    // a result or the end of a skipped tail starts a new parse
    if (emit.valid || (skipping && ch == ipv6tp_pkg::CH_NUL)) begin
      group_acc_next     = '0;
      group_cnt_next     = '0;
      gap_pos_next       = '0;
      gap_seen_next      = 1'b0;
      after_colon_next   = 1'b0;
      at_first_char_next = 1'b1;
    end
    if (emit.valid) begin
      skipping_next = (emit.kind != ipv6tp_pkg::STOP_NUL);
    end
  end

  // store contents including the group written by this word
  always_comb begin
    store_view = group_store;
    if (wr_en) begin
      store_view[wr_idx] = group_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && wr_en) begin
      group_store[wr_idx] <= group_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_acc     <= '0;
      group_cnt     <= '0;
      gap_pos       <= '0;
      gap_seen      <= 1'b0;
      after_colon   <= 1'b0;
      at_first_char <= 1'b1;
      skipping      <= 1'b0;
    end else if (fire) begin
      group_acc     <= group_acc_next;
      group_cnt     <= group_cnt_next;
      gap_pos       <= gap_pos_next;
      gap_seen      <= gap_seen_next;
      after_colon   <= after_colon_next;
      at_first_char <= at_first_char_next;
      skipping      <= skipping_next;
    end
  end

endmodule

FILE: design/ipv6tp_expand.sv
// zero-run expansion of the stored groups into the 128-bit address
module ipv6tp_expand (
  input  ipv6tp_pkg::expand_ctl_t           ctl,
  input  ipv6tp_pkg::group_vec_t            store_view,
  output logic [ipv6tp_pkg::HALF_W-1:0]     addr_high,
  output logic [ipv6tp_pkg::HALF_W-1:0]     addr_low
);

  logic [ipv6tp_pkg::GCNT_W-1:0] missing;
  logic [ipv6tp_pkg::GCNT_W-1:0] run_end;
  ipv6tp_pkg::group_vec_t        g;

  assign missing = ipv6tp_pkg::GCNT_W'(ipv6tp_pkg::NUM_GROUPS) - ctl.count;
  assign run_end = {1'b0, ctl.gap_pos} + missing;

  always_comb begin
    for (int i = 0; i < ipv6tp_pkg::NUM_GROUPS; i++) begin
      g[i] = '0;
      if (ctl.good) begin
        if (!ctl.gap_seen || missing == '0) begin
          if (ipv6tp_pkg::GCNT_W'(i) < ctl.count) begin
            g[i] = store_view[i];
          end
        end else if (ipv6tp_pkg::GCNT_W'(i) < {1'b0, ctl.gap_pos}) begin
          g[i] = store_view[i];
        end else if (ipv6tp_pkg::GCNT_W'(i) >= run_end) begin
          g[i] = store_view[3'(ipv6tp_pkg::GCNT_W'(i) - missing)];
        end
      end
    end
  end

  assign addr_high = {g[0], g[1], g[2], g[3]};
  assign addr_low  = {g[4], g[5], g[6], g[7]};

endmodule
